// ===== hdl/dldf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dldf_pkg
// Shared constants and types of the delimited message deframer.
// ============================================================================
package dldf_pkg;

    localparam int          BYTE_W          = 8;
    localparam int          MAX_PAYLOAD_DEF = 63;
    localparam logic [7:0]  DELIM_RESET     = 8'h24;   // '$'

    // bank handed back by the drain side once its last byte is read
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

// ===== hdl/dldf_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dldf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module dldf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dldf_fifo2.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dldf_fifo2
// Two-entry register FIFO with occupancy output; the writer never pushes full.
// ============================================================================
module dldf_fifo2 #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    output logic [1:0]   o_occ
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_occ, n_occ;

    // occupancy follows push and pop
    always_comb begin
        n_occ = r_occ;
        if (i_push && !i_pop) begin
            n_occ = r_occ + 2'd1;
        end else if (!i_push && i_pop) begin
            n_occ = r_occ - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_occ != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign o_occ   = r_occ;

endmodule

// ===== hdl/dldf_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dldf_front
// Receive side: framing state machine, writes bytes into the current bank and
// queues a descriptor for every good message that a delimiter closes.
// ============================================================================
module dldf_front import dldf_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    localparam int IDX_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int DESC_W = IDX_W + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BYTE_W-1:0] i_cfg_data,
    // byte input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_line_error,
    // store write
    output logic              o_wr_en,
    output logic [IDX_W:0]    o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data,
    // descriptor queue and bank release
    output logic              o_desc_push,
    output logic [DESC_W-1:0] o_desc_data,
    input  t_release          i_release
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_START   = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PAYLOAD);

    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_bad, n_bad;
    logic              r_ovf, n_ovf;
    logic              r_bank, n_bank;
    logic [1:0]        r_busy, n_busy;
    logic [BYTE_W-1:0] r_delim;

    logic              is_delim, closing, accept;
    logic              wr_bank;
    logic [IDX_W-1:0]  wr_idx;

    // a good close moves to the other bank, which must be drained by then
    assign is_delim   = (i_rx_byte == r_delim);
    assign closing    = (r_phase == PH_PAYLOAD) && !i_line_error && is_delim && !r_bad;
    assign o_in_ready = !(closing && r_busy[~r_bank]);
    assign accept     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // framing
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_bad       = r_bad;
        n_ovf       = r_ovf;
        n_bank      = r_bank;
        o_wr_en     = 1'b0;
        wr_bank     = r_bank;
        wr_idx      = '0;
        o_desc_push = 1'b0;
        if (accept) begin
            if (i_line_error) begin
                n_bad = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_START: begin
                        if (is_delim) begin
                            n_idx   = '0;
                            n_bad   = 1'b0;
                            n_ovf   = 1'b0;
                            o_wr_en = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_idx   = IDX_W'(1);
                            o_wr_en = 1'b1;
                            wr_idx  = IDX_W'(1);
                        end
                    end
                    PH_PAYLOAD: begin
                        if (is_delim) begin
                            if (!r_bad) begin
                                o_desc_push = 1'b1;
                                n_bank      = ~r_bank;
                            end
                            n_phase = PH_START;
                            n_idx   = '0;
                            n_bad   = 1'b0;
                            n_ovf   = 1'b0;
                            o_wr_en = 1'b1;
                            wr_bank = n_bank;
                        end else if (r_idx < MAX_IDX) begin
                            n_idx   = r_idx + IDX_W'(1);
                            o_wr_en = 1'b1;
                            wr_idx  = n_idx;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    default: begin
                        if (is_delim) begin
                            n_phase = PH_START;
                            n_idx   = '0;
                            n_bad   = 1'b0;
                            n_ovf   = 1'b0;
                            o_wr_en = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // bank ownership
    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_desc_push) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_bad   <= 1'b0;
            r_ovf   <= 1'b0;
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
            r_delim <= DELIM_RESET;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_bad   <= n_bad;
            r_ovf   <= n_ovf;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
            if (i_cfg_valid) begin
                r_delim <= i_cfg_data;
            end
        end
    end

    assign o_wr_addr   = {wr_bank, wr_idx};
    assign o_wr_data   = i_rx_byte;
    assign o_desc_data = {r_bank, r_idx, r_ovf};

    // checks
    a_push_free_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc_push |-> !r_busy[r_bank])
        else $error("descriptor pushed for a bank still draining");
    a_push_flips_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc_push |=> (r_bank != $past(r_bank)))
        else $error("write bank did not switch after a close");
    a_stall_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((r_phase == PH_PAYLOAD) && !r_bad && r_busy[~r_bank]))
        else $error("input stalled outside a blocked close");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= MAX_IDX)
        else $error("payload index beyond maximum");

endmodule

// ===== hdl/dldf_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dldf_back
// Drain side: reads queued messages out of their bank byte by byte into a
// two-entry output FIFO, and hands each bank back after its last read.
// ============================================================================
module dldf_back import dldf_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    localparam int IDX_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int DESC_W = IDX_W + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // descriptor queue
    input  logic              i_desc_valid,
    input  logic [DESC_W-1:0] i_desc_data,
    output logic              o_desc_pop,
    // store read
    output logic              o_rd_en,
    output logic [IDX_W:0]    o_rd_addr,
    input  logic [BYTE_W-1:0] i_rd_data,
    output t_release          o_release,
    // message output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_msg_byte,
    output logic              o_last,
    output logic              o_truncated
);

    localparam int OUT_W = BYTE_W + 2;

    logic             r_act;
    logic             r_bank;
    logic [IDX_W-1:0] r_len;
    logic             r_trunc;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_inf, r_inf_last, r_inf_trunc;

    logic             d_bank, d_trunc;
    logic [IDX_W-1:0] d_len;
    logic [1:0]       f_occ;
    logic [OUT_W-1:0] f_data;
    logic             pop, issue_ok, issue, last_issue, start;

    assign d_bank  = i_desc_data[DESC_W-1];
    assign d_len   = i_desc_data[DESC_W-2:1];
    assign d_trunc = i_desc_data[0];

    // read only when the FIFO has room for the byte in flight
    assign pop        = o_out_valid && i_out_ready;
    assign issue_ok   = ({1'b0, f_occ} + {2'b00, r_inf} - {2'b00, pop}) < 3'd2;
    assign issue      = r_act && issue_ok;
    assign last_issue = issue && (r_rd_idx == r_len);
    assign start      = (!r_act || last_issue) && i_desc_valid;

    assign o_desc_pop      = start;
    assign o_rd_en         = issue;
    assign o_rd_addr       = {r_bank, r_rd_idx};
    assign o_release.valid = last_issue;
    assign o_release.bank  = r_bank;

    // read sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_inf <= 1'b0;
        end else begin
            r_inf <= issue;
            if (start) begin
                r_act <= 1'b1;
            end else if (last_issue) begin
                r_act <= 1'b0;
            end
        end
    end

    // message context and read-side tags
    always_ff @(posedge i_clk) begin
        r_inf_last  <= last_issue;
        r_inf_trunc <= r_trunc;
        if (start) begin
            r_bank   <= d_bank;
            r_len    <= d_len;
            r_trunc  <= d_trunc;
            r_rd_idx <= '0;
        end else if (issue) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
    end

    dldf_fifo2 #(
        .W(OUT_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_inf),
        .i_data  ({i_rd_data, r_inf_last, r_inf_trunc}),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (f_data),
        .o_occ   (f_occ)
    );

    assign o_msg_byte  = f_data[OUT_W-1:2];
    assign o_last      = f_data[1];
    assign o_truncated = f_data[0];

endmodule

// ===== hdl/dollar_delimited_deframer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dollar_delimited_deframer
// Delimiter-started message deframer: collects bytes into a double-banked
// store and replays each good closed message, delimiter first, last marked.
// ============================================================================
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (delimiter)
//  in       | in        | i_in_valid  / o_in_ready  | i_rx_byte, i_line_error
//  out      | out       | o_out_valid / i_out_ready | o_msg_byte, o_last,
//           |           |                           | o_truncated
//
//  One input byte per cycle unless the input stalls; a message leaves at one
//  byte per cycle while i_out_ready is high, passing the queue, store read and
//  FIFO after its closing delimiter. The input stalls only on a closing
//  delimiter while the other bank of the store is still being read out.
//  Reset is synchronous; the store needs no clearing, every read entry is
//  written first. The config port is always ready.
// ============================================================================
module dollar_delimited_deframer import dldf_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_line_error,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_msg_byte,
    output logic              o_last,
    output logic              o_truncated
);

    localparam int IDX_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int DESC_W = IDX_W + 2;

    logic              wr_en, rd_en;
    logic [IDX_W:0]    wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;
    logic              desc_push, desc_pop, desc_valid;
    logic [DESC_W-1:0] desc_in, desc_out;
    logic [1:0]        desc_occ;
    t_release          release_bank;

    dldf_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_line_error (i_line_error),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_desc_push  (desc_push),
        .o_desc_data  (desc_in),
        .i_release    (release_bank)
    );

    // descriptor queue: at most one entry per bank
    dldf_fifo2 #(
        .W(DESC_W)
    ) u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_data  (desc_in),
        .i_pop   (desc_pop),
        .o_valid (desc_valid),
        .o_data  (desc_out),
        .o_occ   (desc_occ)
    );

    // two banks of message store, bank in the top address bit
    dldf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (2 ** (IDX_W + 1))
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    dldf_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc_data  (desc_out),
        .o_desc_pop   (desc_pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_release    (release_bank),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_msg_byte   (o_msg_byte),
        .o_last       (o_last),
        .o_truncated  (o_truncated)
    );

    // queue never overflows: each entry holds a busy bank
    a_desc_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        desc_push |-> (desc_occ != 2'd2) || desc_pop)
        else $error("descriptor queue overflow");

endmodule

// ===== dv/tb_dollar_delimited_deframer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_dollar_delimited_deframer
// Self-checking bench for the delimiter-started deframer. A scoreboard class
// tracks the framing state of the byte stream, queues every byte of each good
// closed message, and compares the output transactions against them in order.
// Directed framing corner cases are followed by random message traffic under
// several delimiter values and idle/stall profiles.
// ============================================================================
module tb_dollar_delimited_deframer;
    import dldf_pkg::*;

    localparam int STORE_DEPTH   = MAX_PAYLOAD_DEF + 1;
    localparam int IDLE_LIMIT    = 4000;   // cycles with no transaction at all
    localparam int DRAIN_SETTLE  = 16;     // queue + store read + FIFO, padded
    localparam int PHASE_ITEMS   = 20;

    typedef enum logic [1:0] {
        RX_IDLE    = 2'd0,
        RX_START   = 2'd1,
        RX_PAYLOAD = 2'd2
    } t_rx_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] msg_byte;
        logic              last;
        logic              truncated;
    } t_msg_beat;

    // framing predictor plus in-order compare of emitted message bytes
    class frame_scoreboard;
        logic [BYTE_W-1:0] delim;
        t_rx_phase         phase;
        int unsigned       stored;
        bit                bad;
        bit                dropped;
        logic [BYTE_W-1:0] store [STORE_DEPTH];
        t_msg_beat         beat_q [$];
        int unsigned       mismatches;
        int unsigned       beats_checked;
        int unsigned       bytes_taken;
        int unsigned       msgs_emitted;
        int unsigned       msgs_truncated;

        function new();
            delim          = DELIM_RESET;
            phase          = RX_IDLE;
            stored         = 0;
            bad            = 1'b0;
            dropped        = 1'b0;
            mismatches     = 0;
            beats_checked  = 0;
            bytes_taken    = 0;
            msgs_emitted   = 0;
            msgs_truncated = 0;
        endfunction

        function void set_delimiter(logic [BYTE_W-1:0] d);
            delim = d;
        endfunction

        function void open_message(logic [BYTE_W-1:0] first_byte);
            phase    = RX_START;
            stored   = 0;
            bad      = 1'b0;
            dropped  = 1'b0;
            store[0] = first_byte;
        endfunction

        // delimiter first, then payload; truncated flag on every byte
        function void queue_message();
            t_msg_beat b;
            for (int k = 0; k <= stored; k++) begin
                b.msg_byte  = store[k];
                b.last      = (k == stored);
                b.truncated = dropped;
                beat_q.push_back(b);
            end
            msgs_emitted++;
            if (dropped) msgs_truncated++;
        endfunction

        function void note_input(logic [BYTE_W-1:0] rx, logic err);
            bytes_taken++;
            // errored byte is ignored but spoils the open message
            if (err) begin
                bad = 1'b1;
                return;
            end
            case (phase)
                RX_START: begin
                    if (rx == delim) begin
                        open_message(rx);
                    end else begin
                        phase    = RX_PAYLOAD;
                        stored   = 1;
                        store[1] = rx;
                    end
                end
                RX_PAYLOAD: begin
                    if (rx == delim) begin
                        if (!bad) queue_message();
                        open_message(rx);
                    end else if (stored < MAX_PAYLOAD_DEF) begin
                        stored++;
                        store[stored] = rx;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                default: begin
                    if (rx == delim) open_message(rx);
                end
            endcase
        endfunction

        function void check_beat(t_msg_beat got);
            t_msg_beat want;
            if (beat_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected output: byte=%02h last=%0b trunc=%0b",
                             $realtime, got.msg_byte, got.last, got.truncated);
                return;
            end
            want = beat_q.pop_front();
            beats_checked++;
            if (got.msg_byte !== want.msg_byte || got.last !== want.last ||
                got.truncated !== want.truncated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                             $realtime, want.msg_byte, want.last, want.truncated,
                             got.msg_byte, got.last, got.truncated);
            end
        endfunction

        function int pending();
            return beat_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [BYTE_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              i_line_error;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [BYTE_W-1:0] o_msg_byte;
    logic              o_last;
    logic              o_truncated;

    frame_scoreboard   sb = new();
    int unsigned       idle_pct  = 0;
    int unsigned       stall_pct = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       settings_used = 0;

    dollar_delimited_deframer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_line_error (i_line_error),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_msg_byte   (o_msg_byte),
        .o_last       (o_last),
        .o_truncated  (o_truncated)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // output side: random backpressure, compare at the accepting edge
    initial begin
        t_msg_beat got;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= stall_pct);
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.msg_byte  = o_msg_byte;
                got.last      = o_last;
                got.truncated = o_truncated;
                sb.check_beat(got);
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("[%0t] watchdog: no transaction for %0d cycles", $realtime,
                         IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // one input transaction; valid held until accepted
    task automatic send_item(input logic [BYTE_W-1:0] rx, input logic err);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_rx_byte    = rx;
        i_line_error = err;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(rx, err);
    endtask

    // drop valid, let the block drain, then write the delimiter register
    task automatic write_delimiter(input logic [BYTE_W-1:0] d);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_delimiter(d);
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // delimiter plus len payload bytes, optionally sprinkled with line errors
    task automatic send_message(input int unsigned len, input int unsigned err_pct);
        logic [BYTE_W-1:0] b;
        send_item(sb.delim, 1'b0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(99) < err_pct)
                send_item(BYTE_W'($urandom_range(255)), 1'b1);
            b = BYTE_W'($urandom_range(255));
            if (b == sb.delim) b = b + 8'd1;
            send_item(b, 1'b0);
        end
    endtask

    // random traffic under one delimiter and one idle/stall profile
    task automatic run_phase(input int unsigned in_idle, input int unsigned out_stall,
                             input logic [BYTE_W-1:0] d, input bit with_long);
        int unsigned start_cnt;
        int unsigned pick;
        int unsigned err_pct;
        write_delimiter(d);
        idle_pct  = in_idle;
        stall_pct = out_stall;
        if (with_long) send_message($urandom_range(66, 62), 0);
        start_cnt = sb.bytes_taken;
        while (sb.bytes_taken - start_cnt < PHASE_ITEMS) begin
            pick    = $urandom_range(99);
            err_pct = ($urandom_range(99) < 20) ? 15 : 0;
            if (pick < 6)
                send_message(0, 0);                             // empty message
            else if (pick < 10)
                send_message($urandom_range(66, 61), err_pct);  // near the length cap
            else
                send_message($urandom_range(8, 1), err_pct);
        end
        send_item(d, 1'b0);   // close the open message
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_rx_byte    = '0;
        i_line_error = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset delimiter, no idling
        send_item(8'h41, 1'b1);          // error while idle
        send_item(8'h5a, 1'b0);          // noise while idle
        send_item(DELIM_RESET, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(DELIM_RESET, 1'b0);    // closes a good message
        send_item(DELIM_RESET, 1'b0);    // delimiter right after start: restart
        send_item(8'h78, 1'b0);
        send_item(DELIM_RESET, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(DELIM_RESET, 1'b1);    // errored byte with delimiter value
        send_item(8'h62, 1'b0);
        send_item(DELIM_RESET, 1'b0);    // bad message closed silently
        send_item(8'h63, 1'b0);
        send_item(DELIM_RESET, 1'b0);    // next message starts clean
        send_item(8'h7f, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(DELIM_RESET, 1'b0);
        send_item(8'h55, 1'b1);          // error while start seen
        send_item(8'h11, 1'b0);
        send_item(DELIM_RESET, 1'b0);

        // random phases across delimiter extremes and handshake profiles
        run_phase(0,  0,  8'h00, 1'b0);
        run_phase(56, 0,  8'hff, 1'b0);
        run_phase(0,  56, BYTE_W'($urandom_range(255)), 1'b1);
        run_phase(21, 21, DELIM_RESET, 1'b0);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);

        $display("Covered %0d input bytes, %0d output bytes checked, %0d messages",
                 sb.bytes_taken, sb.beats_checked, sb.msgs_emitted);
        $display("%0d truncated; %0d delimiter writes over four handshake profiles; %0d errors",
                 sb.msgs_truncated, settings_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            if (sb.pending() != 0)
                $display("%0d expected output bytes never arrived", sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dldf_pkg.sv
hdl/dldf_ram.sv
hdl/dldf_fifo2.sv
hdl/dldf_front.sv
hdl/dldf_back.sv
hdl/dollar_delimited_deframer.sv
dv/tb_dollar_delimited_deframer.sv
